// ===== src/kick_chip_charge_sequencer_macros.svh =====
// Assertion macros for the checker file of the kicker sequencer.
// No dependencies; included by files that hold concurrent assertions.
`ifndef KICK_CHIP_CHARGE_SEQUENCER_MACROS_SVH
`define KICK_CHIP_CHARGE_SEQUENCER_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define KCCS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define KCCS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/kccs_pkg.sv =====
// Package for the kick/chip charge sequencer: item structs, codes, defaults.
// No dependencies; imported by every module of the block.
`default_nettype none

package kccs_pkg;

  localparam int unsigned TimerWidthDefault = 16;
  localparam int unsigned PeriodWidth       = 16;
  localparam int unsigned RateWidth         = 8;
  localparam int unsigned MaxPercent        = 100;

  // Register reset values
  localparam logic [PeriodWidth-1:0] ChargePollReset = 16'd2000;
  localparam logic [PeriodWidth-1:0] TopupReset      = 16'd20000;
  localparam logic [RateWidth-1:0]   KickRateReset   = 8'd4;
  localparam logic [RateWidth-1:0]   ChipRateReset   = 8'd6;

  // Input item function codes
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_SHOOT = 2'd1,
    FUNC_START = 2'd2,
    FUNC_STOP  = 2'd3
  } func_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CHARGE_POLL = 2'd0,
    CFG_TOPUP       = 2'd1,
    CFG_KICK_RATE   = 2'd2,
    CFG_CHIP_RATE   = 2'd3
  } cfg_index_e;

  // Mode codes as reported on the result item
  localparam logic [1:0] ModeCodeIdle     = 2'd0;
  localparam logic [1:0] ModeCodeCharging = 2'd1;
  localparam logic [1:0] ModeCodeReady    = 2'd2;
  localparam logic [1:0] ModeCodeKicking  = 2'd3;

  // Sequencer state, one-hot
  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_CHARGING = 4'b0010,
    ST_READY    = 4'b0100,
    ST_KICKING  = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] power_percent;
    logic       use_kick;
    logic       charge_done_n;
  } in_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       kick_drive;
    logic       chip_drive;
    logic       charge_drive;
    logic       shot_accepted;
  } out_item_t;

  typedef struct packed {
    logic [PeriodWidth-1:0] charge_poll_ticks;
    logic [PeriodWidth-1:0] topup_ticks;
    logic [RateWidth-1:0]   kick_ticks_per_percent;
    logic [RateWidth-1:0]   chip_ticks_per_percent;
  } cfg_regs_t;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] c;
    unique case (m)
      ST_IDLE:     c = ModeCodeIdle;
      ST_CHARGING: c = ModeCodeCharging;
      ST_READY:    c = ModeCodeReady;
      ST_KICKING:  c = ModeCodeKicking;
      default:     c = ModeCodeIdle;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/kccs_core.sv =====
// Sequencer state and one-item update: mode, one-shot tick timer, drive levels.
// Depends on kccs_pkg.
`default_nettype none

module kccs_core
  import kccs_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TimerWidthDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire in_item_t  item_i,
  input  wire cfg_regs_t cfg_i,
  output out_item_t      result_o
);

  localparam int unsigned LimExtW = TIMER_WIDTH + PeriodWidth;

  // Clamp a period register to the timer range
  function automatic logic [TIMER_WIDTH-1:0] sat_limit(logic [PeriodWidth-1:0] v);
    logic [LimExtW-1:0] ext;
    logic [LimExtW-1:0] mx;
    ext = LimExtW'(v);
    mx  = (LimExtW'(1) << TIMER_WIDTH) - LimExtW'(1);
    return (ext > mx) ? mx[TIMER_WIDTH-1:0] : ext[TIMER_WIDTH-1:0];
  endfunction

  mode_e                  mode_q, mode_d, exp_mode;
  logic [TIMER_WIDTH-1:0] count_q, count_d, count_inc;
  logic [TIMER_WIDTH-1:0] limit_q, limit_d;
  logic                   timer_on_q, timer_on_d;
  logic                   topup_q, topup_d;
  logic                   kick_q, kick_d;
  logic                   chip_q, chip_d;
  logic                   charge_q, charge_d;
  logic                   do_expire;
  logic                   accepted;
  logic [6:0]             pct_clamped;
  logic [RateWidth-1:0]   per;
  logic [14:0]            shot_ticks;

  // Pulse length: clamped percent times ticks per percent
  assign pct_clamped = (item_i.power_percent > 8'(MaxPercent)) ?
                       7'(MaxPercent) : item_i.power_percent[6:0];
  assign per         = item_i.use_kick ? cfg_i.kick_ticks_per_percent
                                       : cfg_i.chip_ticks_per_percent;
  assign shot_ticks  = 15'(pct_clamped) * 15'(per);
  assign count_inc   = count_q + TIMER_WIDTH'(1);

  // Next state for one item
  always_comb begin
    mode_d     = mode_q;
    count_d    = count_q;
    limit_d    = limit_q;
    timer_on_d = timer_on_q;
    topup_d    = topup_q;
    kick_d     = kick_q;
    chip_d     = chip_q;
    charge_d   = charge_q;
    do_expire  = 1'b0;
    exp_mode   = mode_q;
    accepted   = 1'b0;

    case (item_i.func)
      FUNC_TICK: begin
        if (timer_on_q) begin
          count_d = count_inc;
          if (count_inc >= limit_q) begin
            do_expire = 1'b1;
          end
        end
      end
      FUNC_SHOOT: begin
        if ((item_i.power_percent != 8'd0) && (mode_q == ST_READY)) begin
          mode_d     = ST_KICKING;
          charge_d   = 1'b0;
          kick_d     = kick_q | item_i.use_kick;
          chip_d     = chip_q | !item_i.use_kick;
          limit_d    = sat_limit(PeriodWidth'(shot_ticks));
          count_d    = '0;
          timer_on_d = 1'b1;
          accepted   = 1'b1;
        end
      end
      FUNC_START: begin
        mode_d    = ST_CHARGING;
        kick_d    = 1'b0;
        chip_d    = 1'b0;
        charge_d  = 1'b1;
        topup_d   = 1'b0;
        do_expire = 1'b1;
        exp_mode  = ST_CHARGING;
      end
      FUNC_STOP: begin
        timer_on_d = 1'b0;
        count_d    = '0;
        mode_d     = ST_IDLE;
        kick_d     = 1'b0;
        chip_d     = 1'b0;
        charge_d   = 1'b0;
      end
      default: ;
    endcase

    // Timer expiry, or the immediate check after a start
    if (do_expire) begin
      unique case (exp_mode)
        ST_KICKING: begin
          kick_d     = 1'b0;
          chip_d     = 1'b0;
          mode_d     = ST_CHARGING;
          charge_d   = 1'b1;
          limit_d    = sat_limit(cfg_i.charge_poll_ticks);
          count_d    = '0;
          timer_on_d = 1'b1;
        end
        ST_CHARGING: begin
          if (!item_i.charge_done_n) begin
            charge_d = 1'b0;
            mode_d   = ST_READY;
            topup_d  = 1'b0;
          end
          limit_d    = sat_limit(cfg_i.charge_poll_ticks);
          count_d    = '0;
          timer_on_d = 1'b1;
        end
        ST_READY: begin
          charge_d   = topup_q;
          topup_d    = !topup_q;
          limit_d    = sat_limit(cfg_i.topup_ticks);
          count_d    = '0;
          timer_on_d = 1'b1;
        end
        default: begin
          timer_on_d = 1'b0;
          count_d    = '0;
        end
      endcase
    end
  end

  assign result_o.mode          = mode_code(mode_d);
  assign result_o.kick_drive    = kick_d;
  assign result_o.chip_drive    = chip_d;
  assign result_o.charge_drive  = charge_d;
  assign result_o.shot_accepted = accepted;

  // State registers, updated once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ST_IDLE;
      count_q    <= '0;
      limit_q    <= '0;
      timer_on_q <= 1'b0;
      topup_q    <= 1'b0;
      kick_q     <= 1'b0;
      chip_q     <= 1'b0;
      charge_q   <= 1'b0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      count_q    <= count_d;
      limit_q    <= limit_d;
      timer_on_q <= timer_on_d;
      topup_q    <= topup_d;
      kick_q     <= kick_d;
      chip_q     <= chip_d;
      charge_q   <= charge_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/kick_chip_charge_sequencer.sv =====
// Solenoid kick/chip charge sequencer: two-stage item pipeline around
// the sequencer core, plus the configuration registers. Depends on kccs_pkg, kccs_core.
//
// Each input item (timer tick, shoot, start, stop) gives exactly one result item
// that reports the mode and drive levels after it. The block takes one item per
// clock while results are not stalled: an item is held in the input register, the
// core updates its state and the result is captured in the output register. A
// result is offered from the output register after the core steps on its item; a
// stalled result can delay that step. The state update of the core is the loop that sets
// this rate, one compare, increment and mode step per item. The input register keeps
// accepting while a result waits at the output; input ready drops only when both
// registers hold items and the result is stalled. Configuration writes are always
// taken and should be issued while no item is in flight.
`default_nettype none

module kick_chip_charge_sequencer
  import kccs_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TimerWidthDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire in_item_t               in_item_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output out_item_t                   out_item_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [1:0]             cfg_index_i,
  input  wire logic [PeriodWidth-1:0] cfg_data_i
);

  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t out_q;
  logic      out_vld_q;
  out_item_t result;
  cfg_regs_t cfg_q;
  logic      advance;
  logic      step;

  // Pipeline control
  assign advance    = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    if (step) begin
      out_q <= result;
    end
  end

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.charge_poll_ticks      <= ChargePollReset;
      cfg_q.topup_ticks            <= TopupReset;
      cfg_q.kick_ticks_per_percent <= KickRateReset;
      cfg_q.chip_ticks_per_percent <= ChipRateReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_CHARGE_POLL: cfg_q.charge_poll_ticks      <= cfg_data_i;
        CFG_TOPUP:       cfg_q.topup_ticks            <= cfg_data_i;
        CFG_KICK_RATE:   cfg_q.kick_ticks_per_percent <= cfg_data_i[RateWidth-1:0];
        CFG_CHIP_RATE:   cfg_q.chip_ticks_per_percent <= cfg_data_i[RateWidth-1:0];
        default: ;
      endcase
    end
  end

  kccs_core #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_q),
    .cfg_i   (cfg_q),
    .result_o(result)
  );

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== src/kccs_checker.sv =====
// Port-level checks for the kick/chip charge sequencer, bound to the top level.
// Depends on kccs_pkg and kick_chip_charge_sequencer_macros.svh.
`default_nettype none
`include "kick_chip_charge_sequencer_macros.svh"

module kccs_checker
  import kccs_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_i
);

  // Stalled result item holds
  `KCCS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i), "result item changed while stalled")

  // A solenoid is driven exactly when kicking, and only one of them
  `KCCS_ASSERT(a_drive_mode, clk_i, rst_ni, out_valid_i |-> ((out_item_i.mode == ModeCodeKicking) == (out_item_i.kick_drive ^ out_item_i.chip_drive)) && !(out_item_i.kick_drive && out_item_i.chip_drive), "solenoid drive does not match mode")

  // Idle means every output is off
  `KCCS_ASSERT(a_idle_off, clk_i, rst_ni, out_valid_i && (out_item_i.mode == ModeCodeIdle) |-> !out_item_i.charge_drive && !out_item_i.kick_drive && !out_item_i.chip_drive, "output on while idle")

  // An accepted shot leaves the block kicking with the charger off
  `KCCS_ASSERT(a_shot_kicking, clk_i, rst_ni, out_valid_i && out_item_i.shot_accepted |-> (out_item_i.mode == ModeCodeKicking) && !out_item_i.charge_drive, "accepted shot not kicking")

  // No result item is offered while reset is held
  `KCCS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_i, "result item during reset")

endmodule

bind kick_chip_charge_sequencer kccs_checker u_kccs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_i (out_item_o)
);

`default_nettype wire

// ===== bench/tb_kick_chip_charge_sequencer.sv =====
// Self-checking bench for the kick/chip charge sequencer: random and directed items,
// predicted in-bench and compared field by field. Depends on kccs_pkg and the block.
`timescale 1ns / 1ps

module tb_kick_chip_charge_sequencer;
  import kccs_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ReportMax  = 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_item_t   in_item_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [PeriodWidth-1:0] cfg_data_i = '0;

  kick_chip_charge_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Commands waiting to be sent, and status items expected back
  in_item_t  pending_cmds[$];
  out_item_t expected_status[$];

  int unsigned cycle_count    = 0;
  int unsigned accepted_items = 0;
  int unsigned result_count   = 0;
  int unsigned mismatches     = 0;
  logic        in_took        = 1'b0;
  logic        hold_off       = 1'b0;

  // Shadow configuration
  logic [PeriodWidth-1:0] poll_period  = ChargePollReset;
  logic [PeriodWidth-1:0] topup_period = TopupReset;
  logic [RateWidth-1:0]   kick_rate    = KickRateReset;
  logic [RateWidth-1:0]   chip_rate    = ChipRateReset;

  // Shadow sequencer state
  logic [1:0]  seq_mode        = ModeCodeIdle;
  logic [15:0] seq_ticks       = '0;
  logic [15:0] seq_limit       = '0;
  logic        seq_timer_on    = 1'b0;
  logic        seq_topup_phase = 1'b0;
  logic        seq_kick        = 1'b0;
  logic        seq_chip        = 1'b0;
  logic        seq_charge      = 1'b0;

  // One-shot timer restart, limit saturates at the timer range
  function automatic void restart_timer(logic [31:0] limit);
    seq_limit    = (limit > 32'hFFFF) ? 16'hFFFF : limit[15:0];
    seq_ticks    = '0;
    seq_timer_on = 1'b1;
  endfunction

  // Timer expiry, also run right after a start
  function automatic void on_expiry(logic done_n);
    case (seq_mode)
      ModeCodeKicking: begin
        seq_kick   = 1'b0;
        seq_chip   = 1'b0;
        seq_mode   = ModeCodeCharging;
        seq_charge = 1'b1;
        restart_timer(32'(poll_period));
      end
      ModeCodeCharging: begin
        if (!done_n) begin
          seq_charge      = 1'b0;
          seq_mode        = ModeCodeReady;
          seq_topup_phase = 1'b0;
        end
        restart_timer(32'(poll_period));
      end
      ModeCodeReady: begin
        seq_charge      = seq_topup_phase;
        seq_topup_phase = !seq_topup_phase;
        restart_timer(32'(topup_period));
      end
      default: begin
        seq_timer_on = 1'b0;
        seq_ticks    = '0;
      end
    endcase
  endfunction

  // Next status of the sequencer for one command
  function automatic out_item_t advance_sequencer(in_item_t cmd);
    out_item_t  st;
    logic [7:0] pct;
    logic [7:0] rate;
    logic       shot;
    shot = 1'b0;
    case (cmd.func)
      FUNC_TICK: begin
        if (seq_timer_on) begin
          seq_ticks = seq_ticks + 16'd1;
          if (seq_ticks >= seq_limit) on_expiry(cmd.charge_done_n);
        end
      end
      FUNC_SHOOT: begin
        if (cmd.power_percent >= 8'd1 && seq_mode == ModeCodeReady) begin
          pct = (cmd.power_percent > 8'(MaxPercent)) ? 8'(MaxPercent) : cmd.power_percent;
          rate = cmd.use_kick ? kick_rate : chip_rate;
          seq_mode   = ModeCodeKicking;
          seq_charge = 1'b0;
          if (cmd.use_kick) seq_kick = 1'b1;
          else seq_chip = 1'b1;
          restart_timer(32'(pct) * 32'(rate));
          shot = 1'b1;
        end
      end
      FUNC_START: begin
        seq_mode        = ModeCodeCharging;
        seq_kick        = 1'b0;
        seq_chip        = 1'b0;
        seq_charge      = 1'b1;
        seq_topup_phase = 1'b0;
        on_expiry(cmd.charge_done_n);
      end
      default: begin
        seq_timer_on = 1'b0;
        seq_ticks    = '0;
        seq_mode     = ModeCodeIdle;
        seq_kick     = 1'b0;
        seq_chip     = 1'b0;
        seq_charge   = 1'b0;
      end
    endcase
    st.mode          = seq_mode;
    st.kick_drive    = seq_kick;
    st.chip_drive    = seq_chip;
    st.charge_drive  = seq_charge;
    st.shot_accepted = shot;
    return st;
  endfunction

  function automatic void check_status(out_item_t got);
    out_item_t want;
    result_count++;
    if (expected_status.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportMax)
        $display("result %0d: unexpected item mode=%0d kick=%b chip=%b charge=%b shot=%b",
                 result_count, got.mode, got.kick_drive, got.chip_drive,
                 got.charge_drive, got.shot_accepted);
      return;
    end
    want = expected_status.pop_front();
    if (got.mode !== want.mode || got.kick_drive !== want.kick_drive ||
        got.chip_drive !== want.chip_drive || got.charge_drive !== want.charge_drive ||
        got.shot_accepted !== want.shot_accepted) begin
      mismatches++;
      if (mismatches <= ReportMax)
        $display("result %0d: expected mode=%0d kick=%b chip=%b charge=%b shot=%b, got mode=%0d kick=%b chip=%b charge=%b shot=%b",
                 result_count, want.mode, want.kick_drive, want.chip_drive,
                 want.charge_drive, want.shot_accepted, got.mode, got.kick_drive,
                 got.chip_drive, got.charge_drive, got.shot_accepted);
    end
  endfunction

  // Monitor: check results, predict on accepted items, track register writes
  always @(posedge clk_i) begin
    cycle_count++;
    in_took <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_status(out_item_o);
      if (in_valid_i && in_ready_o) begin
        expected_status.push_back(advance_sequencer(in_item_i));
        accepted_items++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_CHARGE_POLL: poll_period  = cfg_data_i;
          CFG_TOPUP:       topup_period = cfg_data_i;
          CFG_KICK_RATE:   kick_rate    = cfg_data_i[RateWidth-1:0];
          default:         chip_rate    = cfg_data_i[RateWidth-1:0];
        endcase
      end
    end
  end

  // Driver: bursts of items with random gaps
  int unsigned burst_left = 8;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_took) begin
      // hold the offered item
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid_i <= 1'b0;
    end else if (pending_cmds.size() > 0) begin
      in_valid_i <= 1'b1;
      in_item_i  <= pending_cmds.pop_front();
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver: segments of always-ready, random, or periodic stalls
  int unsigned rx_left  = 0;
  int unsigned rx_style = 0;
  logic        rx_next;

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_style = $urandom_range(0, 2);
      rx_left  = $urandom_range(5, 60);
    end
    rx_left--;
    case (rx_style)
      0:       rx_next = 1'b1;
      1:       rx_next = 1'($urandom_range(0, 1));
      default: rx_next = (rx_left % 4) != 0;
    endcase
    out_ready_i <= rst_ni && !hold_off && rx_next;
  end

  // Long receiver hold-offs so the block fills and stalls its input
  initial begin
    wait (accepted_items >= 400);
    @(negedge clk_i) hold_off <= 1'b1;
    repeat (80) @(negedge clk_i);
    hold_off <= 1'b0;
    wait (accepted_items >= 900);
    @(negedge clk_i) hold_off <= 1'b1;
    repeat (60) @(negedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("kick_chip_charge_sequencer verification failed");
    $finish;
  end

  function automatic in_item_t make_cmd(func_e f, logic [7:0] pct, logic kick, logic done_n);
    in_item_t c;
    c.func          = f;
    c.power_percent = pct;
    c.use_kick      = kick;
    c.charge_done_n = done_n;
    return c;
  endfunction

  // Mostly ticks, so timed sequences run through; power biased to small values
  function automatic in_item_t random_cmd();
    in_item_t    c;
    int unsigned sel;
    int unsigned pr;
    sel = $urandom_range(0, 99);
    pr  = $urandom_range(0, 99);
    if (sel < 78) c.func = FUNC_TICK;
    else if (sel < 88) c.func = FUNC_SHOOT;
    else if (sel < 97) c.func = FUNC_START;
    else c.func = FUNC_STOP;
    if (pr < 8) c.power_percent = 8'd0;
    else if (pr < 16) c.power_percent = 8'($urandom_range(101, 255));
    else if (pr < 20) c.power_percent = 8'(MaxPercent);
    else if (pr < 26) c.power_percent = 8'd1;
    else c.power_percent = 8'($urandom_range(2, 20));
    c.use_kick      = 1'($urandom_range(0, 1));
    c.charge_done_n = ($urandom_range(0, 3) == 0);
    return c;
  endfunction

  task automatic write_reg(cfg_index_e idx, logic [PeriodWidth-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] poll, logic [15:0] topup, logic [15:0] kick,
                           logic [15:0] chip);
    write_reg(CFG_CHARGE_POLL, poll);
    write_reg(CFG_TOPUP, topup);
    write_reg(CFG_KICK_RATE, kick);
    write_reg(CFG_CHIP_RATE, chip);
  endtask

  task automatic queue_random(int unsigned n);
    repeat (n) pending_cmds.push_back(random_cmd());
  endtask

  // Wait until every command is sent and answered, then a short settle
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid_i || expected_status.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    // Reset edge lands after every process has started
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed pass at reset defaults
    pending_cmds.push_back(make_cmd(FUNC_TICK, 8'd0, 1'b0, 1'b0));    // tick with timer stopped
    pending_cmds.push_back(make_cmd(FUNC_SHOOT, 8'd50, 1'b1, 1'b0));  // shoot in idle
    pending_cmds.push_back(make_cmd(FUNC_STOP, 8'd0, 1'b0, 1'b1));
    pending_cmds.push_back(make_cmd(FUNC_START, 8'd0, 1'b0, 1'b1));   // not charged yet
    pending_cmds.push_back(make_cmd(FUNC_TICK, 8'd0, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(FUNC_SHOOT, 8'd80, 1'b1, 1'b0));  // shoot while charging
    pending_cmds.push_back(make_cmd(FUNC_START, 8'd0, 1'b0, 1'b0));   // restart, charged
    pending_cmds.push_back(make_cmd(FUNC_SHOOT, 8'd0, 1'b1, 1'b0));   // zero power
    pending_cmds.push_back(make_cmd(FUNC_SHOOT, 8'd255, 1'b1, 1'b0)); // clamped kick
    pending_cmds.push_back(make_cmd(FUNC_SHOOT, 8'd20, 1'b0, 1'b0));  // shoot while kicking
    pending_cmds.push_back(make_cmd(FUNC_TICK, 8'd0, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(FUNC_START, 8'd0, 1'b0, 1'b0));   // start while kicking
    pending_cmds.push_back(make_cmd(FUNC_SHOOT, 8'd1, 1'b1, 1'b0));   // minimum kick
    repeat (4) pending_cmds.push_back(make_cmd(FUNC_TICK, 8'd0, 1'b0, 1'b1));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 8'd0, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(FUNC_START, 8'd0, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(FUNC_SHOOT, 8'd100, 1'b0, 1'b0)); // full chip
    pending_cmds.push_back(make_cmd(FUNC_STOP, 8'd0, 1'b0, 1'b0));    // stop mid pulse
    pending_cmds.push_back(make_cmd(FUNC_TICK, 8'd0, 1'b0, 1'b0));
    pending_cmds.push_back(make_cmd(FUNC_START, 8'd0, 1'b0, 1'b1));
    pending_cmds.push_back(make_cmd(FUNC_STOP, 8'd0, 1'b0, 1'b1));
    pending_cmds.push_back(make_cmd(FUNC_SHOOT, 8'd101, 1'b0, 1'b0));
    wait_drained();

    // Shortest periods
    write_all(16'd1, 16'd1, 16'd1, 16'd1);
    queue_random(150);
    wait_drained();

    // Zero periods: every armed timer expires on the next tick
    write_all(16'd0, 16'd0, 16'd0, 16'd0);
    queue_random(120);
    wait_drained();

    // Small random periods, junk in the unused upper byte of the kick rate
    write_all(16'($urandom_range(1, 6)), 16'($urandom_range(1, 12)),
              {8'($urandom_range(0, 255)), 8'($urandom_range(1, 4))},
              16'($urandom_range(1, 4)));
    queue_random(320);
    wait_drained();

    // Largest values
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF);
    queue_random(100);
    wait_drained();

    write_all(16'($urandom_range(1, 5)), 16'($urandom_range(1, 8)),
              16'($urandom_range(1, 3)), 16'($urandom_range(1, 3)));
    queue_random(300);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_status.size() == 0)
      $display("kick_chip_charge_sequencer verification clean");
    else
      $display("kick_chip_charge_sequencer verification failed");
    $finish;
  end

endmodule

// ===== kick_chip_charge_sequencer.f =====
+incdir+src
src/kccs_pkg.sv
src/kccs_core.sv
src/kick_chip_charge_sequencer.sv
src/kccs_checker.sv
bench/tb_kick_chip_charge_sequencer.sv
